### hw/rtl/sik_pkg.sv
package sik_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int SQRT_STAGES       = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 31;

    localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS  = 1'b1;

    localparam logic [30:0] LINK_LENGTH_RST = 31'd6553600;
    localparam logic [30:0] MIN_RADIUS_RST  = 31'd4587520;

    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic [29:0]        ELBOW_MAX   = 30'd843314856;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_sik_in;

    typedef struct packed {
        logic signed [31:0] shoulder_angle;
        logic [29:0]        elbow_angle;
        logic signed [31:0] height_out;
        logic               unreachable;
    } t_sik_out;

    // atan(2^-i) in Q4.28, rounded to nearest.
    function automatic logic signed [31:0] atan_q28(input int i);
        logic signed [31:0] v;
        begin
            case (i)
                0:  v = 32'sd210828714;
                1:  v = 32'sd124459457;
                2:  v = 32'sd65760959;
                3:  v = 32'sd33381290;
                4:  v = 32'sd16755422;
                5:  v = 32'sd8385879;
                6:  v = 32'sd4193963;
                7:  v = 32'sd2097109;
                8:  v = 32'sd1048571;
                9:  v = 32'sd524287;
                10: v = 32'sd262144;
                11: v = 32'sd131072;
                12: v = 32'sd65536;
                13: v = 32'sd32768;
                14: v = 32'sd16384;
                15: v = 32'sd8192;
                16: v = 32'sd4096;
                17: v = 32'sd2048;
                18: v = 32'sd1024;
                19: v = 32'sd512;
                20: v = 32'sd256;
                21: v = 32'sd128;
                22: v = 32'sd64;
                23: v = 32'sd32;
                24: v = 32'sd16;
                25: v = 32'sd8;
                26: v = 32'sd4;
                27: v = 32'sd2;
                28: v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

### hw/rtl/scara_inverse_kinematics.sv
// An accepted item passes the input capture, the square, radius and radicand stages, the square-root
// stages, the CORDIC prescale and rotation stages and the output register, which raises o_done.
// Throughput: one item per cycle; o_busy stays low, since every stage moves each cycle.
// The depth is set by the 32-step square-root pipeline and the CORDIC stages.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result is on o_result for exactly one cycle.
module scara_inverse_kinematics #(
    parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  sik_pkg::t_sik_in                 i_item,
    output logic                             o_busy,
    input  logic                             i_cfg_we,
    input  logic [sik_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sik_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_done,
    output sik_pkg::t_sik_out                o_result
);

    localparam int NS = sik_pkg::SQRT_STAGES;

    // Configuration registers.
    logic [30:0] r_link_len, r_min_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_len <= sik_pkg::LINK_LENGTH_RST;
            r_min_rad  <= sik_pkg::MIN_RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sik_pkg::REG_LINK_LENGTH: r_link_len <= i_cfg_data;
                sik_pkg::REG_MIN_RADIUS:  r_min_rad  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Stage 0: input capture.
    logic               r_v0;
    logic signed [31:0] r_x0, r_y0, r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_start;
        r_x0 <= i_item.target_x;
        r_y0 <= i_item.target_y;
        r_z0 <= i_item.target_z;
    end

    // Stage 1: squares.
    logic [31:0] n_ax, n_ay;
    assign n_ax = r_x0[31] ? 32'(-r_x0) : 32'(r_x0);
    assign n_ay = r_y0[31] ? 32'(-r_y0) : 32'(r_y0);

    logic               r_v1;
    logic signed [31:0] r_x1, r_y1, r_z1;
    logic [63:0]        r_sqx1, r_sqy1;
    logic [61:0]        r_l2_1, r_m2_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= r_v0;
        r_x1   <= r_x0;
        r_y1   <= r_y0;
        r_z1   <= r_z0;
        r_sqx1 <= 64'(n_ax) * 64'(n_ax);
        r_sqy1 <= 64'(n_ay) * 64'(n_ay);
        r_l2_1 <= 62'(62'(r_link_len) * 62'(r_link_len));
        r_m2_1 <= 62'(62'(r_min_rad) * 62'(r_min_rad));
    end

    // Stage 2: radius squared and scaled link bounds.
    logic               r_v2;
    logic signed [31:0] r_x2, r_y2, r_z2;
    logic [63:0]        r_r2_2, r_l4_2;
    logic [71:0]        r_l361_2;
    logic [61:0]        r_m2_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_x2     <= r_x1;
        r_y2     <= r_y1;
        r_z2     <= r_z1;
        r_r2_2   <= r_sqx1 + r_sqy1;
        r_l4_2   <= {r_l2_1, 2'b00};
        r_l361_2 <= 72'(r_l2_1) * 72'd361;
        r_m2_2   <= r_m2_1;
    end

    // Stage 3: scaled radius, radicand, inner test.
    logic               r_v3, r_near3;
    logic signed [31:0] r_x3, r_y3, r_z3;
    logic [63:0]        r_r2_3, r_diff3;
    logic [71:0]        r_r100_3, r_l361_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_x3     <= r_x2;
        r_y3     <= r_y2;
        r_z3     <= r_z2;
        r_r2_3   <= r_r2_2;
        r_diff3  <= (r_r2_2 < r_l4_2) ? (r_l4_2 - r_r2_2) : 64'd0;
        r_r100_3 <= 72'(r_r2_2) * 72'd100;
        r_l361_3 <= r_l361_2;
        r_near3  <= (r_r2_2 < 64'(r_m2_2));
    end

    // Square-root pipeline: one result bit per stage, both roots side by side.
    logic               r_qvld [0:NS];
    logic               r_qbad [0:NS];
    logic signed [31:0] r_qx   [0:NS];
    logic signed [31:0] r_qy   [0:NS];
    logic signed [31:0] r_qz   [0:NS];
    logic [63:0]        r_rv   [0:NS];
    logic [63:0]        r_rres [0:NS];
    logic [63:0]        r_sv   [0:NS];
    logic [63:0]        r_sres [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qvld[0] <= 1'b0;
        else          r_qvld[0] <= r_v3;
        r_qbad[0] <= r_near3 || (r_r100_3 > r_l361_3);
        r_qx[0]   <= r_x3;
        r_qy[0]   <= r_y3;
        r_qz[0]   <= r_z3;
        r_rv[0]   <= r_r2_3;
        r_rres[0] <= 64'd0;
        r_sv[0]   <= r_diff3;
        r_sres[0] <= 64'd0;
    end

    for (genvar gi = 0; gi < NS; gi++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
        logic [63:0] n_rt, n_st;
        assign n_rt = r_rres[gi] + BIT;
        assign n_st = r_sres[gi] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_qvld[gi+1] <= 1'b0;
            else          r_qvld[gi+1] <= r_qvld[gi];
            r_qbad[gi+1] <= r_qbad[gi];
            r_qx[gi+1]   <= r_qx[gi];
            r_qy[gi+1]   <= r_qy[gi];
            r_qz[gi+1]   <= r_qz[gi];
            if (r_rv[gi] >= n_rt) begin
                r_rv[gi+1]   <= r_rv[gi] - n_rt;
                r_rres[gi+1] <= (r_rres[gi] >> 1) + BIT;
            end else begin
                r_rv[gi+1]   <= r_rv[gi];
                r_rres[gi+1] <= r_rres[gi] >> 1;
            end
            if (r_sv[gi] >= n_st) begin
                r_sv[gi+1]   <= r_sv[gi] - n_st;
                r_sres[gi+1] <= (r_sres[gi] >> 1) + BIT;
            end else begin
                r_sv[gi+1]   <= r_sv[gi];
                r_sres[gi+1] <= r_sres[gi] >> 1;
            end
        end
    end

    // CORDIC prescale and left-half-plane turn: result is {x, y, angle}.
    function automatic logic [159:0] pre_rot(input logic signed [63:0] px,
                                             input logic signed [63:0] py);
        logic signed [63:0] x, y;
        logic signed [31:0] a;
        begin
            x = px;
            y = py;
            a = 32'sd0;
            if (px < 0) begin
                if (py >= 0) begin
                    x = py;
                    y = -px;
                    a = sik_pkg::HALF_PI_Q28;
                end else begin
                    x = -py;
                    y = px;
                    a = -sik_pkg::HALF_PI_Q28;
                end
            end
            return {x, y, a};
        end
    endfunction

    logic [63:0] n_phx, n_phy, n_hfx, n_hfy;
    assign n_phx = {{8{r_qx[NS][31]}}, r_qx[NS], 24'd0};
    assign n_phy = {{8{r_qy[NS][31]}}, r_qy[NS], 24'd0};
    assign n_hfx = {8'd0, r_rres[NS][31:0], 24'd0};
    assign n_hfy = {8'd0, r_sres[NS][31:0], 24'd0};

    logic               r_cvld  [0:CORDIC_STAGES];
    logic               r_cbad  [0:CORDIC_STAGES];
    logic               r_pzero [0:CORDIC_STAGES];
    logic               r_hzero [0:CORDIC_STAGES];
    logic signed [31:0] r_cz    [0:CORDIC_STAGES];
    logic signed [63:0] r_px    [0:CORDIC_STAGES];
    logic signed [63:0] r_py    [0:CORDIC_STAGES];
    logic signed [31:0] r_pa    [0:CORDIC_STAGES];
    logic signed [63:0] r_hx    [0:CORDIC_STAGES];
    logic signed [63:0] r_hy    [0:CORDIC_STAGES];
    logic signed [31:0] r_ha    [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cvld[0] <= 1'b0;
        else          r_cvld[0] <= r_qvld[NS];
        r_cbad[0]  <= r_qbad[NS];
        r_cz[0]    <= r_qz[NS];
        r_pzero[0] <= (r_qx[NS] == 32'sd0) && (r_qy[NS] == 32'sd0);
        r_hzero[0] <= (r_rres[NS] == 64'd0) && (r_sres[NS] == 64'd0);
        {r_px[0], r_py[0], r_pa[0]} <= pre_rot(n_phx, n_phy);
        {r_hx[0], r_hy[0], r_ha[0]} <= pre_rot(n_hfx, n_hfy);
    end

    // Vectoring rotations; y >= 0 counts as positive.
    for (genvar gc = 0; gc < CORDIC_STAGES; gc++) begin : g_cordic
        localparam logic signed [31:0] ATAN = sik_pkg::atan_q28(gc);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cvld[gc+1] <= 1'b0;
            else          r_cvld[gc+1] <= r_cvld[gc];
            r_cbad[gc+1]  <= r_cbad[gc];
            r_cz[gc+1]    <= r_cz[gc];
            r_pzero[gc+1] <= r_pzero[gc];
            r_hzero[gc+1] <= r_hzero[gc];
            if (r_py[gc] >= 0) begin
                r_px[gc+1] <= r_px[gc] + (r_py[gc] >>> gc);
                r_py[gc+1] <= r_py[gc] - (r_px[gc] >>> gc);
                r_pa[gc+1] <= r_pa[gc] + ATAN;
            end else begin
                r_px[gc+1] <= r_px[gc] - (r_py[gc] >>> gc);
                r_py[gc+1] <= r_py[gc] + (r_px[gc] >>> gc);
                r_pa[gc+1] <= r_pa[gc] - ATAN;
            end
            if (r_hy[gc] >= 0) begin
                r_hx[gc+1] <= r_hx[gc] + (r_hy[gc] >>> gc);
                r_hy[gc+1] <= r_hy[gc] - (r_hx[gc] >>> gc);
                r_ha[gc+1] <= r_ha[gc] + ATAN;
            end else begin
                r_hx[gc+1] <= r_hx[gc] - (r_hy[gc] >>> gc);
                r_hy[gc+1] <= r_hy[gc] + (r_hx[gc] >>> gc);
                r_ha[gc+1] <= r_ha[gc] - ATAN;
            end
        end
    end

    // Output stage: clamp the half angle and assemble the item.
    logic signed [31:0] n_phi, n_half;

    always_comb begin
        n_phi  = r_pzero[CORDIC_STAGES] ? 32'sd0 : r_pa[CORDIC_STAGES];
        n_half = r_ha[CORDIC_STAGES];
        if (r_hzero[CORDIC_STAGES] || n_half < 0) n_half = 32'sd0;
        if (n_half > sik_pkg::HALF_PI_Q28)        n_half = sik_pkg::HALF_PI_Q28;
    end

    logic              r_done;
    sik_pkg::t_sik_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_cvld[CORDIC_STAGES];
        r_res.height_out <= r_cz[CORDIC_STAGES];
        if (r_cbad[CORDIC_STAGES]) begin
            r_res.shoulder_angle <= 32'sd0;
            r_res.elbow_angle    <= 30'd0;
            r_res.unreachable    <= 1'b1;
        end else begin
            r_res.shoulder_angle <= n_phi + n_half;
            r_res.elbow_angle    <= {n_half[28:0], 1'b0};
            r_res.unreachable    <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### hw/rtl/sik_checker.sv
module sik_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_busy,
    input logic                           o_done,
    input sik_pkg::t_sik_out              o_result
);

    // An unreachable item carries zero angles.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.unreachable) |->
        (o_result.shoulder_angle == 32'sd0 && o_result.elbow_angle == 30'd0))
        else $error("unreachable item with nonzero angles");

    // The elbow angle never exceeds pi.
    a_elbow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.elbow_angle <= sik_pkg::ELBOW_MAX))
        else $error("elbow angle out of range");

    // The elbow angle is twice a half angle, so it is always even.
    a_elbow_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.elbow_angle[0] == 1'b0))
        else $error("odd elbow angle");

    // The pipeline never refuses an item.
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy asserted");

endmodule

bind scara_inverse_kinematics sik_checker u_sik_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
